[rtl/core/itoa_pkg.sv]
// Shared constants and the binary-to-BCD step function for the decimal text converter.
`default_nettype none

package itoa_pkg;

    localparam int BIN_W      = 32;               // input magnitude width
    localparam int DIGITS     = 10;               // decimal digits of a 32-bit magnitude
    localparam int BCD_W      = 4 * DIGITS;
    localparam int SH_W       = BCD_W + BIN_W;    // BCD field above binary field
    localparam int STEPS      = 4;                // shift steps per pipeline stage
    localparam int DAB_STAGES = BIN_W / STEPS;
    localparam int NSTAGES    = DAB_STAGES + 1;   // negate stage plus dabble stages
    localparam int IDX_W      = $clog2(DIGITS);

    localparam logic [5:0] CODE_ZERO  = 6'd48;
    localparam logic [5:0] CODE_MINUS = 6'd45;

    typedef logic [SH_W-1:0]  shift_t;
    typedef logic [IDX_W-1:0] digit_idx_t;

    // STEPS iterations of double dabble: add 3 to digits >= 5, then shift left
    function automatic shift_t dabble_steps(input shift_t sh_in);
        shift_t sh;
        sh = sh_in;
        for (int s = 0; s < STEPS; s++)
        begin
            for (int d = 0; d < DIGITS; d++)
            begin
                if (sh[BIN_W + 4*d +: 4] >= 4'd5)
                begin
                    sh[BIN_W + 4*d +: 4] = sh[BIN_W + 4*d +: 4] + 4'd3;
                end
            end
            sh = {sh[SH_W-2:0], 1'b0};
        end
        return sh;
    endfunction

endpackage

`default_nettype wire

[rtl/core/signed_int_to_decimal_ascii.sv]
// Top level: signed 32-bit integer to decimal ASCII characters, pipelined.
//
// Usage:
//   Input channel (value, value_valid, value_stall): one signed 32-bit word is
//   taken at a rising edge with value_valid high and value_stall low.
//   Output channel (char_code, last_char, char_valid, char_stall): one ASCII
//   character per digit, most significant first; a leading '-' for negative
//   input; last_char marks the final digit. Zero gives a single '0'.
// Path: a word taken at an edge loads the negate stage, then passes eight
//   double-dabble stages of four shifts each, the serializer and the output
//   register before its first character shows on char_valid.
// Throughput: while char_stall is low the serializer sends one character per
//   cycle; a word has 1 to 11 characters, and back-to-back words keep the
//   output busy every cycle. The pipeline accepts one word per cycle until it
//   fills behind the serializer.
// Reset: rst_n (async, active low) empties every stage, the serializer and the
//   output register; nothing is kept between words.
// Stall: char_stall holds the output register; the serializer, then the stages
//   behind it, stop in turn and value_stall rises once stage zero is occupied
//   and cannot move. No word is lost or repeated.
`default_nettype none

module signed_int_to_decimal_ascii
    import itoa_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // input words
    input  wire logic signed [31:0] value,
    input  wire logic              value_valid,
    output logic                   value_stall,
    // output characters
    output logic [5:0]             char_code,
    output logic                   last_char,
    output logic                   char_valid,
    input  wire logic              char_stall
);

    // ---------------- conversion pipeline ----------------
    // Stage 0 holds sign and magnitude; stages 1..DAB_STAGES run double dabble.
    logic [NSTAGES-1:0] vld_reg;
    logic [NSTAGES-1:0] neg_reg;
    shift_t             sh_reg [NSTAGES];
    logic [NSTAGES:0]   rdy;          // rdy[i]: stage i may load this cycle

    // serializer
    logic       ser_vld_reg;
    logic       ser_neg_reg;          // minus sign still to be sent
    digit_idx_t ser_idx_reg;          // digit sent next, counts down to zero
    logic [3:0] ser_dig_reg [DIGITS];

    // output register
    logic       char_valid_reg;
    logic [5:0] char_code_reg;
    logic       last_char_reg;

    logic       out_adv;
    logic       emit;
    logic       emit_last;
    logic       ser_free;
    logic [BIN_W-1:0] bits;
    logic [BIN_W-1:0] mag;
    digit_idx_t top_idx;
    logic [3:0] cur_dig;

    // magnitude as unsigned 32 bits: the most negative value needs no special case
    assign bits = BIN_W'(value);
    assign mag  = bits[BIN_W-1] ? (~bits + 1'b1) : bits;

    assign out_adv   = !char_valid_reg || !char_stall;
    assign emit      = ser_vld_reg && out_adv;
    assign emit_last = !ser_neg_reg && (ser_idx_reg == '0);
    assign ser_free  = !ser_vld_reg || (emit && emit_last);
    assign cur_dig   = ser_dig_reg[ser_idx_reg];

    // backward ready chain through the stages
    always_comb
    begin
        rdy[NSTAGES] = ser_free;
        for (int i = NSTAGES - 1; i >= 0; i--)
        begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    assign value_stall = !rdy[0];

    // most significant nonzero digit of the finished BCD word (0 for zero)
    always_comb
    begin
        top_idx = '0;
        for (int d = 0; d < DIGITS; d++)
        begin
            if (sh_reg[NSTAGES-1][BIN_W + 4*d +: 4] != 4'd0)
            begin
                top_idx = IDX_W'(d);
            end
        end
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                vld_reg[0] <= value_valid;
            end
            for (int i = 1; i < NSTAGES; i++)
            begin
                if (rdy[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (rdy[0] && value_valid)
        begin
            neg_reg[0] <= bits[BIN_W-1];
            sh_reg[0]  <= {{BCD_W{1'b0}}, mag};
        end
        for (int i = 1; i < NSTAGES; i++)
        begin
            if (rdy[i] && vld_reg[i-1])
            begin
                neg_reg[i] <= neg_reg[i-1];
                sh_reg[i]  <= dabble_steps(sh_reg[i-1]);
            end
        end
    end

    // ---------------- serializer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_vld_reg <= 1'b0;
            ser_neg_reg <= 1'b0;
            ser_idx_reg <= '0;
        end
        else if (ser_free && vld_reg[NSTAGES-1])
        begin
            ser_vld_reg <= 1'b1;
            ser_neg_reg <= neg_reg[NSTAGES-1];
            ser_idx_reg <= top_idx;
        end
        else if (emit)
        begin
            if (ser_neg_reg)
            begin
                ser_neg_reg <= 1'b0;
            end
            else if (ser_idx_reg == '0)
            begin
                ser_vld_reg <= 1'b0;
            end
            else
            begin
                ser_idx_reg <= ser_idx_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ser_free && vld_reg[NSTAGES-1])
        begin
            for (int d = 0; d < DIGITS; d++)
            begin
                ser_dig_reg[d] <= sh_reg[NSTAGES-1][BIN_W + 4*d +: 4];
            end
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_valid_reg <= 1'b0;
        end
        else if (out_adv)
        begin
            char_valid_reg <= ser_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            char_code_reg <= ser_neg_reg ? CODE_MINUS : (CODE_ZERO + {2'b00, cur_dig});
            last_char_reg <= emit_last;
        end
    end

    assign char_valid = char_valid_reg;
    assign char_code  = char_code_reg;
    assign last_char  = last_char_reg;

endmodule

`default_nettype wire
